// ===== sv/lswc_pkg.sv =====
// shared types and constants for the lexer split window certifier
package lswc_pkg;

    localparam int NUM_STATES = 64;
    localparam int SW         = 6;
    localparam int MAX_WINDOW = 63;
    localparam int ORIGW      = 64;
    localparam int POSW       = 7;
    localparam int SYMW       = 8;
    localparam int TBL_AW     = SW + SYMW;
    localparam int TBL_DW     = SW + 1;
    localparam int IDXW       = SW + 1;

    typedef enum logic [1:0] {
        REQ_TRANS,
        REQ_FLAGS,
        REQ_BYTE,
        REQ_RSVD
    } t_req;

    typedef enum logic {
        CFG_START_STATE,
        CFG_START_REENTRANT
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_WRITE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [SYMW-1:0] symbol;
        logic [SW-1:0]   state_index;
        logic [SW-1:0]   target_state;
        logic            has_target;
        logic            is_accept;
        logic            is_alive;
        logic            last_byte;
    } t_in;

    typedef struct packed {
        logic          certified;
        logic [SW-1:0] split_offset;
        logic          too_long;
    } t_out;

    typedef struct packed {
        logic              accept;
        logic              clr_we;
        logic [TBL_AW-1:0] clr_addr;
        logic              step_read;
        logic              step_look;
        logic              step_write;
        logic              finish;
        logic [IDXW-1:0]   idx;
    } t_cmd;

    typedef struct packed {
        logic walk;
        logic out_blocked;
    } t_sts;

endpackage

// ===== sv/lswc_ram.sv =====
// generic single write port ram with registered read
module lswc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/lswc_ctrl.sv =====
// controller: table clearing pass and the per-byte sweep over all states
module lswc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_req_type,
    input  lswc_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output lswc_pkg::t_cmd o_cmd
);
    import lswc_pkg::*;

    t_state              r_state, n_state;
    logic [TBL_AW-1:0]   r_clr;
    logic [IDXW-1:0]     r_idx;
    logic                accept;
    logic                is_byte;
    logic                clr_last;
    logic                idx_last;

    assign accept   = i_in_valid && o_in_ready;
    assign is_byte  = i_req_type == REQ_BYTE;
    assign clr_last = r_clr == TBL_AW'((1 << TBL_AW) - 1);
    assign idx_last = r_idx == IDXW'(NUM_STATES);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (clr_last) n_state = ST_IDLE;
            ST_IDLE:   if (accept && is_byte) n_state = i_sts.walk ? ST_READ : ST_FINISH;
            ST_READ:   n_state = ST_LOOK;
            ST_LOOK:   n_state = ST_WRITE;
            ST_WRITE:  n_state = idx_last ? ST_FINISH : ST_READ;
            ST_FINISH: if (!i_sts.out_blocked) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = r_state == ST_IDLE;
        o_cmd            = '0;
        o_cmd.accept     = accept;
        o_cmd.clr_addr   = r_clr;
        o_cmd.idx        = r_idx;
        unique case (r_state)
            ST_CLEAR:  o_cmd.clr_we = 1'b1;
            ST_IDLE:   o_cmd.clr_we = 1'b0;
            ST_READ:   o_cmd.step_read = 1'b1;
            ST_LOOK:   o_cmd.step_look = 1'b1;
            ST_WRITE:  o_cmd.step_write = 1'b1;
            ST_FINISH: o_cmd.finish = !i_sts.out_blocked;
            default:   o_cmd.clr_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ST_IDLE) begin
                r_idx <= '0;
            end else if (r_state == ST_WRITE) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end
endmodule

// ===== sv/lswc_dp.sv =====
// datapath: transition table, flags, ping-pong hypothesis rows and result register
module lswc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lswc_pkg::t_in     i_in,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [5:0]        i_cfg_data,
    input  lswc_pkg::t_cmd    i_cmd,
    input  logic              i_out_ready,
    output lswc_pkg::t_sts    o_sts,
    output logic              o_out_valid,
    output lswc_pkg::t_out    o_out
);
    import lswc_pkg::*;

    localparam logic [ORIGW-1:0] BEFORE = ORIGW'(1) << (ORIGW - 1);

    logic [SW-1:0]     r_start;
    logic              r_reent;
    logic [NUM_STATES-1:0] r_accf, r_live;
    logic [POSW-1:0]   r_pos;
    logic              r_dead, r_sel, r_seed, r_last, r_walk;
    logic [SYMW-1:0]   r_sym;
    logic [SW-1:0]     r_at;
    logic              r_accepting, r_any;
    logic [ORIGW-1:0]  r_all, r_v;
    logic [SW-1:0]     r_t;
    logic              r_go;
    logic [NUM_STATES-1:0] r_vld0, r_vld1;
    logic              r_ovalid;
    t_out              r_out;

    // table memory
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
    logic [TBL_DW-1:0] tbl_wdata, tbl_rdata;
    logic [SW-1:0]     sidx;

    // cloud memories
    logic              ram_we0, ram_we1;
    logic [SW-1:0]     raddr0, raddr1;
    logic [ORIGW-1:0]  rdata0, rdata1, wdata;
    logic [ORIGW-1:0]  cur_dout, nxt_dout, row, here, v, nxt_old, all_or;
    logic [NUM_STATES-1:0] vld_cur, vld_nxt;
    logic              src_ok, go, in_byte, dead_fin, cert;
    logic [SW-1:0]     off, cur_idx;

    assign in_byte  = i_cmd.accept && (i_in.req_type == REQ_BYTE);
    assign cur_idx  = i_cmd.idx[SW-1:0];
    assign sidx     = i_cmd.idx[SW] ? r_start : cur_idx;
    assign here     = ORIGW'(1) << r_at;

    assign tbl_we    = i_cmd.clr_we || (i_cmd.accept && i_in.req_type == REQ_TRANS);
    assign tbl_waddr = i_cmd.clr_we ? i_cmd.clr_addr : {i_in.state_index, i_in.symbol};
    assign tbl_wdata = i_cmd.clr_we ? '0 :
                       (i_in.has_target ? {1'b1, i_in.target_state} : '0);
    assign tbl_raddr = {sidx, r_sym};

    lswc_ram #(.WIDTH(TBL_DW), .DEPTH(1 << TBL_AW)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(tbl_waddr),
        .i_wdata(tbl_wdata),
        .i_raddr(tbl_raddr),
        .o_rdata(tbl_rdata)
    );

    assign cur_dout = r_sel ? rdata1 : rdata0;
    assign nxt_dout = r_sel ? rdata0 : rdata1;
    assign vld_cur  = r_sel ? r_vld1 : r_vld0;
    assign vld_nxt  = r_sel ? r_vld0 : r_vld1;

    // cur is read in the read step, nxt at the looked-up target
    assign raddr0 = r_sel ? tbl_rdata[SW-1:0] : cur_idx;
    assign raddr1 = r_sel ? cur_idx : tbl_rdata[SW-1:0];

    assign nxt_old = vld_nxt[r_t] ? nxt_dout : '0;
    assign wdata   = nxt_old | r_v;
    assign ram_we0 = i_cmd.step_write && r_go && r_sel;
    assign ram_we1 = i_cmd.step_write && r_go && !r_sel;

    lswc_ram #(.WIDTH(ORIGW), .DEPTH(NUM_STATES)) u_cloud0 (
        .i_clk  (i_clk),
        .i_we   (ram_we0),
        .i_waddr(r_t),
        .i_wdata(wdata),
        .i_raddr(raddr0),
        .o_rdata(rdata0)
    );

    lswc_ram #(.WIDTH(ORIGW), .DEPTH(NUM_STATES)) u_cloud1 (
        .i_clk  (i_clk),
        .i_we   (ram_we1),
        .i_waddr(r_t),
        .i_wdata(wdata),
        .i_raddr(raddr1),
        .o_rdata(rdata1)
    );

    // row of the swept state; first byte of a window reads the seed
    always_comb begin
        if (r_seed) begin
            row = r_live[cur_idx] ? BEFORE : '0;
        end else begin
            row = vld_cur[cur_idx] ? cur_dout : '0;
        end
        if (i_cmd.idx[SW]) begin
            src_ok = r_accepting;
            v      = here;
        end else begin
            src_ok = row != '0;
            v      = (cur_idx == r_start && !r_reent) ? here : row;
        end
        go = src_ok && tbl_rdata[SW] && r_live[tbl_rdata[SW-1:0]];
    end

    // result
    assign all_or   = r_all;
    assign dead_fin = r_dead || (r_walk && !r_any);
    always_comb begin
        off = '0;
        for (int k = 0; k < ORIGW - 1; k++) begin
            if (all_or[k]) off = off | SW'(k);
        end
        cert = (r_pos <= POSW'(MAX_WINDOW)) && !dead_fin && !r_accf[r_start]
               && (all_or != '0) && ((all_or & (all_or - 1'b1)) == '0)
               && (all_or != BEFORE);
    end

    assign o_sts.walk        = (r_pos < POSW'(MAX_WINDOW)) && (r_pos == '0 || !r_dead);
    assign o_sts.out_blocked = r_last && r_ovalid && !i_out_ready;
    assign o_out_valid       = r_ovalid;
    assign o_out             = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_reent     <= 1'b0;
            r_accf      <= '0;
            r_live      <= '0;
            r_pos       <= '0;
            r_dead      <= 1'b0;
            r_sel       <= 1'b0;
            r_seed      <= 1'b0;
            r_vld0      <= '0;
            r_vld1      <= '0;
            r_ovalid    <= 1'b0;
            r_walk      <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_START_STATE) begin
                    r_start <= i_cfg_data;
                end else begin
                    r_reent <= i_cfg_data[0];
                end
            end
            if (i_cmd.accept && i_in.req_type == REQ_FLAGS) begin
                r_accf[i_in.state_index] <= i_in.is_accept;
                r_live[i_in.state_index] <= i_in.is_alive;
            end
            // a new result may load in the cycle the old one transfers
            if (i_cmd.finish && r_last) begin
                r_ovalid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (in_byte) begin
                r_sym       <= i_in.symbol;
                r_last      <= i_in.last_byte;
                r_at        <= r_pos[SW-1:0];
                r_walk      <= o_sts.walk;
                r_accepting <= 1'b0;
                r_any       <= 1'b0;
                r_all       <= '0;
                if (r_pos == '0) begin
                    r_seed <= 1'b1;
                    r_dead <= 1'b0;
                end
                if (r_pos <= POSW'(MAX_WINDOW)) begin
                    r_pos <= r_pos + 1'b1;
                end
                if (o_sts.walk) begin
                    if (r_sel) r_vld0 <= '0;
                    else       r_vld1 <= '0;
                end
            end
            if (i_cmd.step_look) begin
                r_v  <= v;
                r_t  <= tbl_rdata[SW-1:0];
                r_go <= go;
                if (!i_cmd.idx[SW] && row != '0 && r_accf[cur_idx]) begin
                    r_accepting <= 1'b1;
                end
            end
            if (i_cmd.step_write && r_go) begin
                if (r_sel) r_vld0[r_t] <= 1'b1;
                else       r_vld1[r_t] <= 1'b1;
                r_any <= 1'b1;
                r_all <= r_all | r_v;
            end
            if (i_cmd.finish) begin
                if (r_walk && r_any) begin
                    r_sel  <= !r_sel;
                    r_seed <= 1'b0;
                end
                if (r_last) begin
                    r_out.certified        <= cert;
                    r_out.split_offset     <= cert ? off : '0;
                    r_out.too_long         <= r_pos > POSW'(MAX_WINDOW);
                    r_pos                  <= '0;
                    r_dead                 <= 1'b0;
                end else if (r_walk && !r_any) begin
                    r_dead <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== sv/lexer_split_window_certifier.sv =====
// top level of the lexer split window certifier
// sequence: table and flag writes are taken in idle; a window byte that is walked steps
// through read, look and write for all 64 states and then the start state, else goes to finish
// throughput: one item at a time, set by the sequential sweep over the hypothesis rows
// reset: synchronous active low; then a clearing pass over all 16384 entries empties the
// transition table, during which no input transfer is taken (config writes still are)
module lexer_split_window_certifier (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lswc_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lswc_pkg::t_out  o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [5:0]      i_cfg_data
);
    import lswc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    lswc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_req_type(i_in.req_type),
        .i_sts     (sts),
        .o_in_ready(o_in_ready),
        .o_cmd     (cmd)
    );

    lswc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_out_ready(i_out_ready),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .o_out      (o_out)
    );
endmodule
